// ===== design/mba_pkg.sv =====
// Shared types and constants for the marker byte allocator.
// Used by mba_ctrl, mba_dpath and marker_byte_allocator; no dependencies.

package mba_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 11;
    localparam int OFFSET_W = 10;
    localparam int COUNT_W  = 11;
    localparam int BASE_W   = 6;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SIZE_W-1:0] MEM_SIZE_RST = 11'd1024;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_ZERO,
        ST_FREE,
        ST_COUNT,
        ST_DONE
    } t_state;

    // Datapath work modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FILL,
        MODE_SCAN,
        MODE_ZERO,
        MODE_FREE,
        MODE_COUNT
    } t_mode;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        t_mode mode;
        logic  to_count;
        logic  emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fill_end;
        logic scan_found;
        logic scan_end;
        logic zero_end;
        logic free_stop;
        logic count_end;
        logic out_busy;
    } t_sts;

    // Marker byte: low six address bits plus base, with the top bit set
    function automatic logic [7:0] marker(input logic [BASE_W-1:0] base,
                                          input logic [BASE_W-1:0] addr_low);
        return {2'b10, base + addr_low};
    endfunction

endpackage

// ===== design/mba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mba_ctrl.sv =====
// Sequencing state machine for the marker byte allocator.
// Depends on mba_pkg; drives mba_dpath through t_cmd, reads t_sts.

module mba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [mba_pkg::KIND_W-1:0] i_kind,
    input  mba_pkg::t_sts              i_sts,
    output logic                       o_in_ready,
    output mba_pkg::t_cmd              o_cmd
);

    mba_pkg::t_state r_state;
    mba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mba_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        mba_pkg::KIND_INIT:  n_state = mba_pkg::ST_INIT;
                        mba_pkg::KIND_ALLOC: n_state = mba_pkg::ST_SCAN;
                        mba_pkg::KIND_FREE:  n_state = mba_pkg::ST_FREE;
                        default:             n_state = mba_pkg::ST_COUNT;
                    endcase
                end
            end
            mba_pkg::ST_INIT: begin
                if (i_sts.fill_end) n_state = mba_pkg::ST_COUNT;
            end
            mba_pkg::ST_SCAN: begin
                if (i_sts.scan_found) begin
                    n_state = mba_pkg::ST_ZERO;
                end else if (i_sts.scan_end) begin
                    n_state = mba_pkg::ST_COUNT;
                end
            end
            mba_pkg::ST_ZERO: begin
                if (i_sts.zero_end) n_state = mba_pkg::ST_COUNT;
            end
            mba_pkg::ST_FREE: begin
                if (i_sts.free_stop) n_state = mba_pkg::ST_COUNT;
            end
            mba_pkg::ST_COUNT: begin
                if (i_sts.count_end) n_state = mba_pkg::ST_DONE;
            end
            mba_pkg::ST_DONE: begin
                if (!i_sts.out_busy) n_state = mba_pkg::ST_IDLE;
            end
            default: n_state = mba_pkg::ST_IDLE;
        endcase
    end

    // Outputs; no item is taken while reset is held
    always_comb begin
        o_in_ready     = (r_state == mba_pkg::ST_IDLE) && i_rst_n;
        o_cmd.load     = (r_state == mba_pkg::ST_IDLE) && i_rst_n && i_in_valid;
        o_cmd.to_count = (r_state != mba_pkg::ST_IDLE) && (r_state != mba_pkg::ST_COUNT)
                         && (n_state == mba_pkg::ST_COUNT);
        o_cmd.emit     = (r_state == mba_pkg::ST_DONE) && !i_sts.out_busy;
        unique case (r_state)
            mba_pkg::ST_INIT:  o_cmd.mode = mba_pkg::MODE_FILL;
            mba_pkg::ST_SCAN:  o_cmd.mode = mba_pkg::MODE_SCAN;
            mba_pkg::ST_ZERO:  o_cmd.mode = mba_pkg::MODE_ZERO;
            mba_pkg::ST_FREE:  o_cmd.mode = mba_pkg::MODE_FREE;
            mba_pkg::ST_COUNT: o_cmd.mode = mba_pkg::MODE_COUNT;
            default:           o_cmd.mode = mba_pkg::MODE_IDLE;
        endcase
    end

endmodule

// ===== design/mba_dpath.sv =====
// Datapath of the marker byte allocator: config registers, pointers, run and
// free counters, result register and the byte store. Depends on mba_pkg, mba_ram.

module mba_dpath #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mba_pkg::KIND_W-1:0]     i_kind,
    input  logic [mba_pkg::SIZE_W-1:0]     i_size,
    input  logic [mba_pkg::OFFSET_W-1:0]   i_offset,
    input  mba_pkg::t_cmd                  i_cmd,
    output mba_pkg::t_sts                  o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_ok,
    output logic [mba_pkg::OFFSET_W-1:0]   o_offset,
    output logic [mba_pkg::COUNT_W-1:0]    o_count
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int NW  = $clog2(MEM_DEPTH + 1);
    localparam int CW  = (NW > 12) ? NW : 12;
    localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);

    // Config registers
    logic [mba_pkg::BASE_W-1:0] r_base;
    logic [mba_pkg::SIZE_W-1:0] r_msize;

    // Item and scan state
    logic [CW-1:0] r_size,    n_size;
    logic [CW-1:0] r_lim,     n_lim;
    logic [CW-1:0] r_ptr,     n_ptr;
    logic          r_rd_vld,  n_rd_vld;
    logic [CW-1:0] r_rd_addr, n_rd_addr;
    logic [CW-1:0] r_run,     n_run;
    logic [CW-1:0] r_first,   n_first;
    logic [CW-1:0] r_zlim,    n_zlim;
    logic [CW-1:0] r_cnt,     n_cnt;
    logic          r_ok,      n_ok;
    logic [CW-1:0] r_where,   n_where;

    // Output register
    logic                         r_out_vld, n_out_vld;
    logic                         r_o_ok,    n_o_ok;
    logic [mba_pkg::OFFSET_W-1:0] r_o_off,   n_o_off;
    logic [mba_pkg::COUNT_W-1:0]  r_o_cnt,   n_o_cnt;

    // Store port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    logic          ptr_lt_n;
    logic          is_mark;
    logic          issue;
    logic          found;
    logic [CW-1:0] first_eff;
    logic [CW-1:0] msize_ext;

    mba_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_msize <= mba_pkg::MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mba_pkg::CFG_BASE: r_base  <= i_cfg_data[mba_pkg::BASE_W-1:0];
                mba_pkg::CFG_SIZE: r_msize <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Status shared with the controller
    always_comb begin
        msize_ext = {{(CW - mba_pkg::SIZE_W){1'b0}}, r_msize};
        ptr_lt_n  = (r_ptr < r_lim);
        is_mark   = r_rd_vld &&
                    (ram_rdata == mba_pkg::marker(r_base, r_rd_addr[5:0]));
        found     = is_mark && ((r_run + CW'(1)) == (r_size + CW'(2)));
        first_eff = (r_run == '0) ? r_rd_addr : r_first;

        o_sts.fill_end   = !ptr_lt_n;
        o_sts.scan_found = found;
        o_sts.scan_end   = !r_rd_vld && !ptr_lt_n;
        o_sts.zero_end   = !(r_ptr < r_zlim);
        o_sts.free_stop  = is_mark || (!r_rd_vld && !ptr_lt_n);
        o_sts.count_end  = !r_rd_vld && !ptr_lt_n;
        o_sts.out_busy   = r_out_vld && !i_out_ready;
    end

    // Next values
    always_comb begin
        n_size    = r_size;
        n_lim     = r_lim;
        n_run     = r_run;
        n_first   = r_first;
        n_zlim    = r_zlim;
        n_cnt     = r_cnt;
        n_ok      = r_ok;
        n_where   = r_where;
        ram_we    = 1'b0;
        ram_waddr = r_ptr[AW-1:0];
        ram_wdata = '0;

        // sequential read of the store, one address per cycle
        issue = ((i_cmd.mode == mba_pkg::MODE_SCAN) || (i_cmd.mode == mba_pkg::MODE_FREE) ||
                 (i_cmd.mode == mba_pkg::MODE_COUNT)) && ptr_lt_n;
        ram_re    = issue;
        n_rd_vld  = issue;
        n_rd_addr = r_ptr;
        n_ptr     = issue ? r_ptr + CW'(1) : r_ptr;

        unique case (i_cmd.mode)
            mba_pkg::MODE_FILL: begin
                if (ptr_lt_n) begin
                    ram_we    = 1'b1;
                    ram_wdata = mba_pkg::marker(r_base, r_ptr[5:0]);
                    n_ptr     = r_ptr + CW'(1);
                end
            end
            mba_pkg::MODE_SCAN: begin
                // track the current run of marker bytes
                if (r_rd_vld) begin
                    if (is_mark) begin
                        n_run = r_run + CW'(1);
                        if (r_run == '0) n_first = r_rd_addr;
                    end else begin
                        n_run = '0;
                    end
                end
                if (found) begin
                    n_ok     = 1'b1;
                    n_where  = first_eff + CW'(1);
                    n_ptr    = first_eff + CW'(1);
                    n_zlim   = first_eff + CW'(1) + r_size;
                    n_rd_vld = 1'b0;
                end
            end
            mba_pkg::MODE_ZERO: begin
                if (r_ptr < r_zlim) begin
                    ram_we = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                end
            end
            mba_pkg::MODE_FREE: begin
                // restore the marker of each byte read until one holds it
                if (r_rd_vld && !is_mark) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_addr[AW-1:0];
                    ram_wdata = mba_pkg::marker(r_base, r_rd_addr[5:0]);
                end
            end
            mba_pkg::MODE_COUNT: begin
                if (is_mark) n_cnt = r_cnt + CW'(1);
            end
            default: ;
        endcase

        // restart the pointer for the closing recount
        if (i_cmd.to_count) begin
            n_ptr    = '0;
            n_rd_vld = 1'b0;
            n_cnt    = '0;
        end

        // take a new item
        if (i_cmd.load) begin
            n_size   = {{(CW - mba_pkg::SIZE_W){1'b0}}, i_size};
            n_lim    = (msize_ext < DEPTH_C) ? msize_ext : DEPTH_C;
            n_ptr    = (i_kind == mba_pkg::KIND_FREE) ?
                       {{(CW - mba_pkg::OFFSET_W){1'b0}}, i_offset} : '0;
            n_run    = '0;
            n_rd_vld = 1'b0;
            n_cnt    = '0;
            n_ok     = 1'b0;
            n_where  = '0;
        end
    end

    // Result register
    always_comb begin
        n_out_vld = r_out_vld;
        n_o_ok    = r_o_ok;
        n_o_off   = r_o_off;
        n_o_cnt   = r_o_cnt;
        if (i_cmd.emit) begin
            n_out_vld = 1'b1;
            n_o_ok    = r_ok;
            n_o_off   = r_where[mba_pkg::OFFSET_W-1:0];
            n_o_cnt   = r_cnt[mba_pkg::COUNT_W-1:0];
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_lim     <= n_lim;
        r_ptr     <= n_ptr;
        r_rd_addr <= n_rd_addr;
        r_run     <= n_run;
        r_first   <= n_first;
        r_zlim    <= n_zlim;
        r_cnt     <= n_cnt;
        r_ok      <= n_ok;
        r_where   <= n_where;
        r_o_ok    <= n_o_ok;
        r_o_off   <= n_o_off;
        r_o_cnt   <= n_o_cnt;
    end

    assign o_out_valid = r_out_vld;
    assign o_ok        = r_o_ok;
    assign o_offset    = r_o_off;
    assign o_count     = r_o_cnt;

endmodule

// ===== design/marker_byte_allocator.sv =====
// Top level of the marker byte allocator: stream ports and config port.
// Depends on mba_pkg, mba_ctrl, mba_dpath (and mba_ram below it).

// First-fit allocator over a MEM_DEPTH-byte store in which every free byte
// holds a marker (low six address bits plus base, top bit set). Items are
// handled one at a time; each walks the store through the single read port
// of the store RAM, one byte per cycle, and every item ends with a recount of
// the n = min(mem_size, MEM_DEPTH) bytes in use. The store needs no clearing
// after reset but must see an init item before anything else. A new item is
// taken while the previous result still waits on the output register.

module marker_byte_allocator #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // alloc_size[10:0], free_offset[20:11]
    input  logic [mba_pkg::KIND_W-1:0]       s_axis_tuser,  // kind[1:0]
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // alloc_offset[9:0], free_count[20:10]
    output logic                             m_axis_tuser   // alloc_ok
);

    mba_pkg::t_cmd cmd;
    mba_pkg::t_sts sts;

    logic [mba_pkg::OFFSET_W-1:0] res_offset;
    logic [mba_pkg::COUNT_W-1:0]  res_count;

    mba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mba_dpath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_size      (s_axis_tdata[10:0]),
        .i_offset    (s_axis_tdata[20:11]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ok        (m_axis_tuser),
        .o_offset    (res_offset),
        .o_count     (res_count)
    );

    // Pack the result fields, padded to whole bytes
    assign m_axis_tdata = {3'b000, res_count, res_offset};

endmodule
